// File: hw/rtl/wmmt_pkg.sv
// Shared constants and types of the windowed max and mean tracker.
package wmmt_pkg;

   localparam int DEFAULT_CHANNELS    = 64;
   localparam int DEFAULT_WINDOW      = 50;
   localparam int DEFAULT_SAMPLE_BITS = 16;

   localparam int CHAN_FIELD_BITS = 6;
   localparam int FIELD_BITS      = 16;
   localparam int COUNT_BITS      = 32;
   localparam int REQ_DATA_BITS   = 24;
   localparam int RSP_DATA_BITS   = 72;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_OLD,
      ST_SCAN,
      ST_WAIT,
      ST_OUT
   } wmmt_state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_TOT,
      PH_DONE
   } wmmt_div_phase_type;

endpackage

// File: hw/rtl/wmmt_div.sv
// Restoring divider, one quotient bit per cycle, quotient known to fit Q_BITS.
module wmmt_div #(
   parameter int N_BITS = 48,
   parameter int D_BITS = 32,
   parameter int Q_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [N_BITS-1:0] dividend,
   input  logic [D_BITS-1:0] divisor,
   output logic              done,
   output logic [Q_BITS-1:0] quotient
);

   localparam int SD_BITS   = D_BITS + Q_BITS;
   localparam int W_BITS    = (N_BITS > SD_BITS) ? N_BITS : SD_BITS;
   localparam int STEP_BITS = $clog2(Q_BITS + 1);

   logic [W_BITS-1:0]    rem_ff, rem_in;
   logic [W_BITS-1:0]    sdiv_ff, sdiv_in;
   logic [Q_BITS-1:0]    q_ff, q_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 ge;

   always_comb begin
      rem_in  = rem_ff;
      sdiv_in = sdiv_ff;
      q_in    = q_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      ge      = rem_ff >= sdiv_ff;
      if (start) begin
         rem_in  = W_BITS'(dividend);
         sdiv_in = W_BITS'(divisor) << (Q_BITS - 1);
         q_in    = '0;
         step_in = STEP_BITS'(Q_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - sdiv_ff;
         end
         q_in    = {q_ff[Q_BITS-2:0], ge};
         sdiv_in = sdiv_ff >> 1;
         step_in = step_ff - STEP_BITS'(1);
         if (step_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      sdiv_ff <= sdiv_in;
      q_ff    <= q_in;
      step_ff <= step_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// File: hw/rtl/windowed_max_mean_tracker.sv
// Windowed max and mean tracker: per-channel sample ring and all-time statistics.
// A word for a valid channel passes LOAD, OLD, SCAN, WAIT and OUT; an out-of-range channel goes
// straight to OUT. The ring scan, one entry per cycle, overlaps the divide for the total mean.
// S = min(SAMPLE_BITS, 16) is the sample width. A new word is taken only once the last result
// is in the output register. Reset: synchronous; a clearing pass then zeroes all CHANNELS*WINDOW
// ring entries and the channel state, with req_tready low throughout.
module windowed_max_mean_tracker #(
   parameter int CHANNELS    = wmmt_pkg::DEFAULT_CHANNELS,
   parameter int WINDOW      = wmmt_pkg::DEFAULT_WINDOW,
   parameter int SAMPLE_BITS = wmmt_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // channel[5:0], sample_mhz[21:6], zero pad
   input  logic [wmmt_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_channel[5:0], window_max[21:6], window_mean[37:22], total_max[53:38],
   // total_mean[69:54], window_full[70], zero pad
   output logic [wmmt_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int FB         = wmmt_pkg::FIELD_BITS;
   localparam int CB         = wmmt_pkg::COUNT_BITS;
   localparam int SW         = (SAMPLE_BITS < FB) ? SAMPLE_BITS : FB;
   localparam int CH_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SLOT_BITS  = $clog2(WINDOW);
   localparam int WSUM_BITS  = SW + $clog2(WINDOW);
   localparam int TSUM_BITS  = SW + CB;
   localparam int RING_DEPTH = CHANNELS * WINDOW;
   localparam int RA_BITS    = $clog2(RING_DEPTH);
   localparam int O_TMAX     = WSUM_BITS;
   localparam int O_TSUM     = O_TMAX + SW;
   localparam int O_CNT      = O_TSUM + TSUM_BITS;
   localparam int O_SLOT     = O_CNT + CB;
   localparam int ST_BITS    = O_SLOT + SLOT_BITS;
   // window mean as window sum times ceil(2^WM_SHIFT / WINDOW), shifted down
   localparam int WM_SHIFT   = WSUM_BITS + SLOT_BITS;
   localparam int WM_M_BITS  = WSUM_BITS + 1;
   localparam int WP_BITS    = 2 * WSUM_BITS + 1;
   localparam logic [WM_M_BITS-1:0] WM_RECIP =
      WM_M_BITS'(((64'd1 << WM_SHIFT) + 64'(WINDOW - 1)) / 64'(WINDOW));

   logic [SW-1:0]      ring_mem [RING_DEPTH];
   logic [ST_BITS-1:0] st_mem   [CHANNELS];

   wmmt_pkg::wmmt_state_type     state_ff, state_in;
   wmmt_pkg::wmmt_div_phase_type phase_ff, phase_in;

   logic [RA_BITS-1:0]   clr_addr_ff, clr_addr_in;
   logic [wmmt_pkg::CHAN_FIELD_BITS-1:0] ch_ff, ch_in;
   logic                 oor_ff, oor_in;
   logic [SW-1:0]        smp_ff, smp_in;
   logic [RA_BITS-1:0]   base_ff, base_in;
   logic [RA_BITS-1:0]   raddr_ff, raddr_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [WSUM_BITS-1:0] wsum_ff, wsum_in;
   logic [TSUM_BITS-1:0] tsum_ff, tsum_in;
   logic [CB-1:0]        cnt_ff, cnt_in;
   logic [SW-1:0]        tmax_ff, tmax_in;
   logic [SLOT_BITS-1:0] scan_idx_ff, scan_idx_in;
   logic                 scan_vld_ff, scan_vld_in;
   logic [SW-1:0]        wmax_ff, wmax_in;
   logic [SW-1:0]        wmean_ff, wmean_in;
   logic [SW-1:0]        tmean_ff, tmean_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [wmmt_pkg::RSP_DATA_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic [SW-1:0]        ring_rd_ff;
   logic [ST_BITS-1:0]   st_rd_ff;

   logic                 ring_we;
   logic [RA_BITS-1:0]   ring_waddr;
   logic [RA_BITS-1:0]   ring_raddr;
   logic [SW-1:0]        ring_wdata;
   logic                 st_we;
   logic [CH_BITS-1:0]   st_waddr;
   logic [CH_BITS-1:0]   st_raddr;
   logic [ST_BITS-1:0]   st_wdata;

   logic [wmmt_pkg::CHAN_FIELD_BITS-1:0] req_ch;
   logic                 in_range;
   logic [SLOT_BITS-1:0] st_slot;
   logic [SLOT_BITS-1:0] slot_eff;
   logic [SLOT_BITS-1:0] slot_next;
   logic [WSUM_BITS-1:0] wsum_new;
   logic [TSUM_BITS-1:0] tsum_new;
   logic [CB-1:0]        cnt_new;
   logic [SW-1:0]        tmax_new;
   logic [WP_BITS-1:0]   wmean_prod;
   logic                 scan_start;
   logic                 div_start;
   logic                 div_done;
   logic [SW-1:0]        div_quot;
   logic                 win_full;

   assign req_ch   = req_tdata[5:0];
   assign in_range = {3'b000, req_ch} < 9'(CHANNELS);
   assign st_raddr = CH_BITS'(req_ch);
   assign st_slot  = st_rd_ff[O_SLOT +: SLOT_BITS];
   assign slot_eff = (32'(st_slot) >= 32'(WINDOW)) ? '0 : st_slot;
   assign slot_next = (slot_ff == SLOT_BITS'(WINDOW - 1)) ? '0 : slot_ff + SLOT_BITS'(1);
   assign wsum_new = wsum_ff - WSUM_BITS'(ring_rd_ff) + WSUM_BITS'(smp_ff);
   assign tmax_new = (smp_ff > tmax_ff) ? smp_ff : tmax_ff;
   assign cnt_new  = (cnt_ff != '1) ? cnt_ff + CB'(1) : cnt_ff;
   assign tsum_new = (cnt_ff != '1) ? tsum_ff + TSUM_BITS'(smp_ff) : tsum_ff;
   assign win_full = cnt_ff >= CB'(WINDOW);
   assign wmean_prod = WP_BITS'(wsum_ff) * WP_BITS'(WM_RECIP);

   assign scan_start = (state_ff == wmmt_pkg::ST_SCAN) && (scan_idx_ff == '0);
   assign div_start  = scan_start;

   wmmt_div #(
      .N_BITS (TSUM_BITS),
      .D_BITS (CB),
      .Q_BITS (SW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (tsum_ff),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      clr_addr_in   = clr_addr_ff;
      ch_in         = ch_ff;
      oor_in        = oor_ff;
      smp_in        = smp_ff;
      base_in       = base_ff;
      raddr_in      = raddr_ff;
      slot_in       = slot_ff;
      wsum_in       = wsum_ff;
      tsum_in       = tsum_ff;
      cnt_in        = cnt_ff;
      tmax_in       = tmax_ff;
      scan_idx_in   = scan_idx_ff;
      scan_vld_in   = 1'b0;
      wmax_in       = wmax_ff;
      wmean_in      = wmean_ff;
      tmean_in      = tmean_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      req_tready    = 1'b0;
      ring_we       = 1'b0;
      ring_waddr    = raddr_ff;
      ring_raddr    = raddr_ff;
      ring_wdata    = smp_ff;
      st_we         = 1'b0;
      st_waddr      = CH_BITS'(ch_ff);
      st_wdata      = {slot_next, cnt_new, tsum_new, tmax_new, wsum_new};

      if (scan_vld_ff && (ring_rd_ff > wmax_ff)) begin
         wmax_in = ring_rd_ff;
      end

      case (phase_ff)
         wmmt_pkg::PH_IDLE: begin
            if (scan_start) begin
               wmean_in = wmean_prod[WM_SHIFT +: SW];
               phase_in = wmmt_pkg::PH_TOT;
            end
         end
         wmmt_pkg::PH_TOT: begin
            if (div_done) begin
               tmean_in = div_quot;
               phase_in = wmmt_pkg::PH_DONE;
            end
         end
         default: begin
         end
      endcase

      case (state_ff)
         wmmt_pkg::ST_CLEAR: begin
            ring_we    = 1'b1;
            ring_waddr = clr_addr_ff;
            ring_wdata = '0;
            if (32'(clr_addr_ff) < 32'(CHANNELS)) begin
               st_we    = 1'b1;
               st_waddr = CH_BITS'(clr_addr_ff);
               st_wdata = '0;
            end
            if (clr_addr_ff == RA_BITS'(RING_DEPTH - 1)) begin
               state_in = wmmt_pkg::ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + RA_BITS'(1);
            end
         end
         wmmt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ch_in    = req_ch;
               oor_in   = !in_range;
               smp_in   = SW'(req_tdata[21:6]);
               base_in  = RA_BITS'(32'(CH_BITS'(req_ch)) * 32'(WINDOW));
               state_in = in_range ? wmmt_pkg::ST_LOAD : wmmt_pkg::ST_OUT;
            end
         end
         wmmt_pkg::ST_LOAD: begin
            raddr_in   = base_ff + RA_BITS'(slot_eff);
            ring_raddr = raddr_in;
            slot_in    = slot_eff;
            wsum_in    = st_rd_ff[0 +: WSUM_BITS];
            tmax_in    = st_rd_ff[O_TMAX +: SW];
            tsum_in    = st_rd_ff[O_TSUM +: TSUM_BITS];
            cnt_in     = st_rd_ff[O_CNT +: CB];
            state_in   = wmmt_pkg::ST_OLD;
         end
         wmmt_pkg::ST_OLD: begin
            ring_we     = 1'b1;
            st_we       = 1'b1;
            wsum_in     = wsum_new;
            tmax_in     = tmax_new;
            tsum_in     = tsum_new;
            cnt_in      = cnt_new;
            scan_idx_in = '0;
            wmax_in     = '0;
            phase_in    = wmmt_pkg::PH_IDLE;
            state_in    = wmmt_pkg::ST_SCAN;
         end
         wmmt_pkg::ST_SCAN: begin
            ring_raddr  = base_ff + RA_BITS'(scan_idx_ff);
            scan_vld_in = 1'b1;
            if (scan_idx_ff == SLOT_BITS'(WINDOW - 1)) begin
               state_in = wmmt_pkg::ST_WAIT;
            end else begin
               scan_idx_in = scan_idx_ff + SLOT_BITS'(1);
            end
         end
         wmmt_pkg::ST_WAIT: begin
            if ((phase_ff == wmmt_pkg::PH_DONE) && !scan_vld_ff) begin
               state_in = wmmt_pkg::ST_OUT;
            end
         end
         wmmt_pkg::ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = '0;
               rsp_tdata_in[5:0] = ch_ff;
               if (!oor_ff) begin
                  rsp_tdata_in[21:6]  = FB'(wmax_ff);
                  rsp_tdata_in[37:22] = FB'(wmean_ff);
                  rsp_tdata_in[53:38] = FB'(tmax_ff);
                  rsp_tdata_in[69:54] = FB'(tmean_ff);
                  rsp_tdata_in[70]    = win_full;
               end
               state_in = wmmt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wmmt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_waddr] <= ring_wdata;
      end
      ring_rd_ff <= ring_mem[ring_raddr];
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[st_waddr] <= st_wdata;
      end
      st_rd_ff <= st_mem[st_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= wmmt_pkg::ST_CLEAR;
         phase_ff      <= wmmt_pkg::PH_IDLE;
         clr_addr_ff   <= '0;
         scan_vld_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         clr_addr_ff   <= clr_addr_in;
         scan_vld_ff   <= scan_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      ch_ff        <= ch_in;
      oor_ff       <= oor_in;
      smp_ff       <= smp_in;
      base_ff      <= base_in;
      raddr_ff     <= raddr_in;
      slot_ff      <= slot_in;
      wsum_ff      <= wsum_in;
      tsum_ff      <= tsum_in;
      cnt_ff       <= cnt_in;
      tmax_ff      <= tmax_in;
      scan_idx_ff  <= scan_idx_in;
      wmax_ff      <= wmax_in;
      wmean_ff     <= wmean_in;
      tmean_ff     <= tmean_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
